>>> rtl/core/qfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfd_pkg
// Shared types for the signed fixed-point divider pipeline.
// ----------------------------------------------------------------------------
package qfd_pkg;

  // Per-item control bits that ride along with the divide datapath
  typedef struct packed {
    logic neg;       // quotient sign: dividend and divisor signs differ
    logic div_zero;  // divisor is zero
  } qfd_flags_t;

endpackage

>>> rtl/core/qfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfd_in_if / qfd_out_if
// Valid/ready stream channels for divider operands and results.
// ----------------------------------------------------------------------------
interface qfd_in_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] dividend;
  logic signed [WORD_BITS-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface qfd_out_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] quotient;
  logic                        error_flag;

  modport source (output valid, output quotient, output error_flag, input ready);
  modport sink   (input valid, input quotient, input error_flag, output ready);
endinterface

>>> rtl/core/q16_fixed_point_divider_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q16_fixed_point_divider_top
// Signed fixed-point divider, Q16.16 by default.
// ----------------------------------------------------------------------------
// Computes (dividend << FRAC_BITS) / divisor on signed WORD_BITS-bit operands,
// truncated toward zero. A zero divisor or a quotient outside the signed
// WORD_BITS range returns quotient 0 with error_flag set. The block accepts
// one operand beat per cycle unless a stalled output backs up the pipeline,
// and returns results in order. The pipeline has one operand stage,
// NUM_STAGES = ceil((WORD_BITS + FRAC_BITS) / STEPS_PER_STAGE) division
// stages that each resolve STEPS_PER_STAGE quotient bits by restoring
// division, and one output stage. At the defaults that is 12 division stages.
// Every stage has its own valid bit and local ready, so a stalled output only
// backs up occupied stages and bubbles are squeezed out.
// ----------------------------------------------------------------------------
module q16_fixed_point_divider_top import qfd_pkg::*; #(
  parameter int FRAC_BITS       = 16,
  parameter int WORD_BITS       = 32,
  parameter int STEPS_PER_STAGE = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qfd_in_if.sink    in_i,
  qfd_out_if.source out_o
);

  localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;
  localparam int NUM_STAGES = (NUM_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int MAX_FLIGHT = NUM_STAGES + 2;
  localparam int CNT_W      = $clog2(MAX_FLIGHT + 1) + 1;

  logic                 st_valid [NUM_STAGES+1];
  logic                 st_ready [NUM_STAGES+1];
  logic [WORD_BITS-1:0] st_rem   [NUM_STAGES+1];
  logic [NUM_BITS-1:0]  st_numq  [NUM_STAGES+1];
  logic [WORD_BITS-1:0] st_mb    [NUM_STAGES+1];
  qfd_flags_t           st_flags [NUM_STAGES+1];

  assign st_rem[0] = '0;

  qfd_prep #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (st_valid[0]),
    .ready_i (st_ready[0]),
    .numq_o  (st_numq[0]),
    .mb_o    (st_mb[0]),
    .flags_o (st_flags[0])
  );

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_div
    localparam int LEFT  = NUM_BITS - g * STEPS_PER_STAGE;
    localparam int STEPS = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;

    qfd_div_stage #(
      .WORD_BITS (WORD_BITS),
      .NUM_BITS  (NUM_BITS),
      .STEPS     (STEPS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[g]),
      .ready_o (st_ready[g]),
      .rem_i   (st_rem[g]),
      .numq_i  (st_numq[g]),
      .mb_i    (st_mb[g]),
      .flags_i (st_flags[g]),
      .valid_o (st_valid[g+1]),
      .ready_i (st_ready[g+1]),
      .rem_o   (st_rem[g+1]),
      .numq_o  (st_numq[g+1]),
      .mb_o    (st_mb[g+1]),
      .flags_o (st_flags[g+1])
    );
  end

  qfd_post #(
    .WORD_BITS (WORD_BITS),
    .NUM_BITS  (NUM_BITS)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid[NUM_STAGES]),
    .ready_o (st_ready[NUM_STAGES]),
    .numq_i  (st_numq[NUM_STAGES]),
    .flags_i (st_flags[NUM_STAGES]),
    .out_o   (out_o)
  );

  // Items in flight, for checking only
  logic [CNT_W-1:0] inflight_q, inflight_d;
  logic             in_beat, out_beat;

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_beat = out_o.valid && out_o.ready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_beat && !out_beat) begin
      inflight_d = inflight_q + 1'b1;
    end else if (!in_beat && out_beat) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // Pipeline can never hold more items than it has stages
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(MAX_FLIGHT))
    else $error("divider holds more items than stages");

  // No result beat without an item in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> inflight_q != '0)
    else $error("result beat with no item in flight");

  // A stalled operand stage keeps its item
  a_prep_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid[0] && !st_ready[0] |=> st_valid[0])
    else $error("operand stage dropped a stalled item");

  // Error results always carry a zero quotient
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error_flag |-> out_o.quotient == '0)
    else $error("error result with nonzero quotient");

endmodule

>>> rtl/core/qfd_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfd_prep
// Input stage: takes operand magnitudes, quotient sign and zero-divisor flag.
// ----------------------------------------------------------------------------
module qfd_prep import qfd_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  qfd_in_if.sink                         in_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [WORD_BITS+FRAC_BITS-1:0] numq_o,
  output logic [WORD_BITS-1:0]           mb_o,
  output qfd_flags_t                     flags_o
);

  logic                 valid_q;
  logic [WORD_BITS-1:0] ma_q, ma_d;
  logic [WORD_BITS-1:0] mb_q, mb_d;
  qfd_flags_t           flags_q, flags_d;
  logic                 a_neg, b_neg;

  assign in_i.ready = !valid_q || ready_i;

  always_comb begin
    a_neg = in_i.dividend[WORD_BITS-1];
    b_neg = in_i.divisor[WORD_BITS-1];
    // most negative input maps to 2^(W-1), still fits unsigned W bits
    ma_d = a_neg ? WORD_BITS'(-in_i.dividend) : WORD_BITS'(in_i.dividend);
    mb_d = b_neg ? WORD_BITS'(-in_i.divisor) : WORD_BITS'(in_i.divisor);
    flags_d.neg      = a_neg ^ b_neg;
    flags_d.div_zero = (in_i.divisor == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ma_q    <= ma_d;
      mb_q    <= mb_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign numq_o  = {ma_q, {FRAC_BITS{1'b0}}};
  assign mb_o    = mb_q;
  assign flags_o = flags_q;

endmodule

>>> rtl/core/qfd_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfd_div_stage
// One pipeline stage of restoring division: STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module qfd_div_stage import qfd_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int NUM_BITS  = 48,
  parameter int STEPS     = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [NUM_BITS-1:0]  numq_i,
  input  logic [WORD_BITS-1:0] mb_i,
  input  qfd_flags_t           flags_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [NUM_BITS-1:0]  numq_o,
  output logic [WORD_BITS-1:0] mb_o,
  output qfd_flags_t           flags_o
);

  logic                 valid_q;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [NUM_BITS-1:0]  numq_q, numq_d;
  logic [WORD_BITS-1:0] mb_q;
  qfd_flags_t           flags_q;

  assign ready_o = !valid_q || ready_i;

  // numq holds unconsumed numerator bits at the top, quotient bits shift
  // in at the bottom; after all stages it is the full quotient.
  always_comb begin
    logic [WORD_BITS+1:0] diff;
    logic                 qbit;
    rem_d  = rem_i;
    numq_d = numq_i;
    for (int s = 0; s < STEPS; s++) begin
      diff   = {1'b0, rem_d, numq_d[NUM_BITS-1]} - {2'b00, mb_i};
      qbit   = !diff[WORD_BITS+1];
      rem_d  = qbit ? diff[WORD_BITS-1:0] : {rem_d[WORD_BITS-2:0], numq_d[NUM_BITS-1]};
      numq_d = {numq_d[NUM_BITS-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rem_q   <= rem_d;
      numq_q  <= numq_d;
      mb_q    <= mb_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign numq_o  = numq_q;
  assign mb_o    = mb_q;
  assign flags_o = flags_q;

endmodule

>>> rtl/core/qfd_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfd_post
// Output stage: overflow check, sign restore and result register.
// ----------------------------------------------------------------------------
module qfd_post import qfd_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int NUM_BITS  = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [NUM_BITS-1:0] numq_i,
  input  qfd_flags_t          flags_i,
  qfd_out_if.source           out_o
);

  logic                 valid_q;
  logic [WORD_BITS-1:0] quot_q, quot_d;
  logic                 err_q, err_d;
  logic                 upper_nz, ovf;
  logic [WORD_BITS-1:0] q_low;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    q_low = numq_i[WORD_BITS-1:0];
    if (NUM_BITS > WORD_BITS) begin
      upper_nz = |(numq_i >> WORD_BITS);
    end else begin
      upper_nz = 1'b0;
    end
    // magnitude above 2^(W-1), or equal to it for a positive result
    ovf = upper_nz ||
          (q_low[WORD_BITS-1] && ((|q_low[WORD_BITS-2:0]) || !flags_i.neg));
    err_d = flags_i.div_zero || ovf;
    if (err_d) begin
      quot_d = '0;
    end else if (flags_i.neg) begin
      quot_d = WORD_BITS'(-q_low);
    end else begin
      quot_d = q_low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      quot_q <= quot_d;
      err_q  <= err_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.quotient   = quot_q;
  assign out_o.error_flag = err_q;

endmodule
